@@ sv/json_source_object_extractor_unit_defines.svh @@
// Assertion macros for the source object extractor
`ifndef JSON_SOURCE_OBJECT_EXTRACTOR_UNIT_DEFINES_SVH
`define JSON_SOURCE_OBJECT_EXTRACTOR_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define JSX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked during reset too
`define JSX_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/jsx_pkg.sv @@
// Types, constants and a function shared by the source object extractor
`timescale 1ns / 1ps
package jsx_pkg;

  localparam int unsigned MAX_DEPTH = 255;
  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned MARKER_LEN = 10;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_OPEN_BRACE = 8'h7b;
  localparam logic [7:0] CH_CLOSE_BRACE = 8'h7d;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_OPEN_BRACKET = 8'h5b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5d;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       in_last;
  } jsx_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       object_start;
    logic       out_last;
    logic       incomplete;
    logic       depth_overflow;
  } jsx_out_t;

  typedef struct packed {
    logic       do_close;
    logic       do_byte;
    logic       do_comma;
    logic       do_open;
    logic [7:0] data;
    logic       data_start;
    logic       incomplete;
    logic       overflow;
  } jsx_cmd_t;

  function automatic logic [7:0] marker_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = CH_QUOTE;
      4'd1: c = CH_UNDERSCORE;
      4'd2: c = 8'h73;
      4'd3: c = 8'h6f;
      4'd4: c = 8'h75;
      4'd5: c = 8'h72;
      4'd6: c = 8'h63;
      4'd7: c = 8'h65;
      4'd8: c = CH_QUOTE;
      4'd9: c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ sv/jsx_front.sv @@
// Front end: scans input items and turns each that yields output into a command
`timescale 1ns / 1ps
module jsx_front import jsx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  jsx_in_t  in_item,
  input  logic     q_full,
  output logic     cmd_push,
  output jsx_cmd_t cmd
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_SEEK = 2'd1;
  localparam logic [1:0] PH_COPY = 2'd2;

  logic [1:0]         phase, phase_next;
  logic [3:0]         progress, progress_next;
  logic [DEPTH_W-1:0] nest_depth, nest_depth_next;
  logic               in_str, in_str_next;
  logic               skip_next, skip_next_next;
  logic               no_object_yet, no_object_yet_next;
  logic               bracket_opened, bracket_opened_next;
  logic               overflow_seen, overflow_seen_next;
  logic               accept;
  logic [3:0]         p;
  logic [7:0]         b;

  assign accept = push && !q_full;
  assign b = in_item.in_byte;

  always_comb begin
    phase_next = phase;
    progress_next = progress;
    nest_depth_next = nest_depth;
    in_str_next = in_str;
    skip_next_next = skip_next;
    no_object_yet_next = no_object_yet;
    bracket_opened_next = 1'b1;
    overflow_seen_next = overflow_seen;
    p = (progress >= 4'(MARKER_LEN)) ? 4'd0 : progress;
    cmd = '0;
    cmd.do_open = !bracket_opened;
    if (in_item.byte_present) begin
      case (phase)
        PH_SEEK: begin
          if (b == CH_OPEN_BRACE) begin
            cmd.do_comma = !no_object_yet;
            cmd.do_byte = 1'b1;
            cmd.data = CH_OPEN_BRACE;
            cmd.data_start = no_object_yet;
            no_object_yet_next = 1'b0;
            phase_next = PH_COPY;
            nest_depth_next = DEPTH_W'(1);
            in_str_next = 1'b0;
            skip_next_next = 1'b0;
          end
        end
        PH_COPY: begin
          cmd.do_byte = 1'b1;
          cmd.data = b;
          if (skip_next) begin
            skip_next_next = 1'b0;
          end else if (in_str) begin
            if (b == CH_BACKSLASH) begin
              skip_next_next = 1'b1;
            end else if (b == CH_QUOTE) begin
              in_str_next = 1'b0;
            end
          end else if (b == CH_QUOTE) begin
            in_str_next = 1'b1;
          end else if (b == CH_OPEN_BRACE) begin
            if (nest_depth >= DEPTH_W'(MAX_DEPTH)) begin
              overflow_seen_next = 1'b1;
            end else begin
              nest_depth_next = nest_depth + DEPTH_W'(1);
            end
          end else if (b == CH_CLOSE_BRACE) begin
            if (nest_depth != '0) begin
              nest_depth_next = nest_depth - DEPTH_W'(1);
            end
            if (nest_depth <= DEPTH_W'(1)) begin
              phase_next = PH_HUNT;
              progress_next = 4'd0;
              in_str_next = 1'b0;
              skip_next_next = 1'b0;
            end
          end
        end
        default: begin
          phase_next = PH_HUNT;
          if (b == marker_char(p)) begin
            if (p == 4'(MARKER_LEN - 1)) begin
              phase_next = PH_SEEK;
              progress_next = 4'd0;
            end else begin
              progress_next = p + 4'd1;
            end
          end else if (p == 4'd9 && b == CH_UNDERSCORE) begin
            progress_next = 4'd2;
          end else if (b == CH_QUOTE) begin
            progress_next = 4'd1;
          end else begin
            progress_next = 4'd0;
          end
        end
      endcase
    end
    if (in_item.in_last) begin
      cmd.do_close = 1'b1;
      cmd.incomplete = (phase_next == PH_COPY);
      cmd.overflow = overflow_seen_next;
      phase_next = PH_HUNT;
      progress_next = 4'd0;
      nest_depth_next = '0;
      in_str_next = 1'b0;
      skip_next_next = 1'b0;
      no_object_yet_next = 1'b1;
      bracket_opened_next = 1'b0;
      overflow_seen_next = 1'b0;
    end
  end

  assign cmd_push = accept && (cmd.do_open || cmd.do_comma || cmd.do_byte || cmd.do_close);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      progress <= 4'd0;
      nest_depth <= '0;
      in_str <= 1'b0;
      skip_next <= 1'b0;
      no_object_yet <= 1'b1;
      bracket_opened <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      progress <= progress_next;
      nest_depth <= nest_depth_next;
      in_str <= in_str_next;
      skip_next <= skip_next_next;
      no_object_yet <= no_object_yet_next;
      bracket_opened <= bracket_opened_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

@@ sv/jsx_queue.sv @@
// Command queue between the front end and the back end
`timescale 1ns / 1ps
module jsx_queue import jsx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr,
  input  jsx_cmd_t wdata,
  input  logic     rd,
  output jsx_cmd_t rdata,
  output logic     full,
  output logic     empty
);

  jsx_cmd_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr, do_rd;

  assign full = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

@@ sv/jsx_back.sv @@
// Back end: expands commands into result items behind an output register
`timescale 1ns / 1ps
module jsx_back import jsx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  jsx_cmd_t q_rdata,
  input  logic     q_empty,
  output logic     q_rd,
  input  logic     pop,
  output logic     empty,
  output jsx_out_t out_item
);

  jsx_cmd_t cur;
  logic [3:0] pending, pending_after, sel;
  logic       out_valid, adv, emit;
  jsx_out_t   res;

  assign adv = !out_valid || pop;
  assign emit = adv && (pending != '0);

  always_comb begin
    sel = pending & (~pending + 4'd1);
    res = '0;
    case (sel)
      4'b0001: res.out_byte = CH_OPEN_BRACKET;
      4'b0010: begin
        res.out_byte = CH_COMMA;
        res.object_start = 1'b1;
      end
      4'b0100: begin
        res.out_byte = cur.data;
        res.object_start = cur.data_start;
      end
      4'b1000: begin
        res.out_byte = CH_CLOSE_BRACKET;
        res.out_last = 1'b1;
        res.incomplete = cur.incomplete;
        res.depth_overflow = cur.overflow;
      end
      default: res = '0;
    endcase
    pending_after = emit ? (pending & ~sel) : pending;
  end

  assign q_rd = (pending_after == '0) && !q_empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_rdata;
    end
    if (emit) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_rd) begin
        pending <= {q_rdata.do_close, q_rdata.do_byte, q_rdata.do_comma, q_rdata.do_open};
      end else begin
        pending <= pending_after;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/json_source_object_extractor_unit.sv @@
// Top level of the source object extractor
//
// Input channel: a queue-style push port. An item (one response byte with
// its present and last flags) is taken at a clock edge with push high and
// full low. The front end classifies each item in the cycle it is taken.
// Result channel: a queue-style pop port. While empty is low, out_item holds
// the oldest result; it is taken at an edge with pop high.
// Each item yields zero to three results: an opening bracket at the start of
// a response, a separator and the copied byte, and a closing bracket on the
// last item, which also carries the incomplete and overflow flags.
// An item's first result passes the command queue, the back end's command
// register and its output register. Throughput: one result per cycle while
// the receiver pops, set by the single output register of the back end; an
// item with several results holds the back end until all have gone out, and
// the four-entry command queue absorbs the difference before full rises.
// Reset (rst, synchronous) clears the scan state, empties the queue and
// drops any result held at the outputs. When the receiver stalls, the
// current result holds, the queue fills, and full then holds off the sender.
`timescale 1ns / 1ps
`include "json_source_object_extractor_unit_defines.svh"
module json_source_object_extractor_unit import jsx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  jsx_in_t  in_item,
  output logic     empty,
  input  logic     pop,
  output jsx_out_t out_item
);

  jsx_cmd_t cmd, q_rdata;
  logic     cmd_push, q_full, q_empty, q_rd;

  assign full = q_full;

  jsx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_item  (in_item),
    .q_full   (q_full),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  jsx_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  jsx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_rdata  (q_rdata),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

  `JSX_ASSERT_IMPL(a_flags_on_last, clk, rst,
    !empty && (out_item.incomplete || out_item.depth_overflow), out_item.out_last,
    "status flag on a result that is not the closing bracket")
  `JSX_ASSERT_IMPL(a_start_byte, clk, rst, !empty && out_item.object_start,
    out_item.out_byte == CH_COMMA || out_item.out_byte == CH_OPEN_BRACE,
    "object start mark on an unexpected byte")
  `JSX_ASSERT_IMPL(a_last_byte, clk, rst, !empty && out_item.out_last,
    out_item.out_byte == CH_CLOSE_BRACKET && !out_item.object_start,
    "last result is not a plain closing bracket")
  `JSX_ASSERT_NEXT(a_reset_empty, clk, rst, empty,
    "result pending right after reset")

endmodule

@@ sim/json_extract_checker.sv @@
// Checker for the source object extractor: predicts the output array text and compares it
`timescale 1ns / 1ps
module json_extract_checker import jsx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  logic     full,
  input  jsx_in_t  in_item,
  input  logic     empty,
  input  logic     pop,
  input  jsx_out_t out_item,
  output int       mismatches,
  output int       pending,
  output int       results_seen,
  output int       objects_seen
);

  typedef enum logic [1:0] {SCAN_HUNT, SCAN_SEEK, SCAN_COPY} scan_phase_e;

  localparam logic [79:0] SOURCE_TAG = "\"_source\":";
  localparam int TAG_LEN = 10;

  scan_phase_e phase;
  int          tag_pos;
  int          depth;
  logic        in_str;
  logic        esc_next;
  logic        first_obj;
  logic        opened;
  logic        too_deep;

  jsx_out_t    array_text_due[$];
  int          bad;
  int          got;
  int          starts;

  function automatic void due(logic [7:0] b, logic s, logic l, logic inc, logic ovf);
    jsx_out_t r;
    r.out_byte       = b;
    r.object_start   = s;
    r.out_last       = l;
    r.incomplete     = inc;
    r.depth_overflow = ovf;
    array_text_due.push_back(r);
  endfunction

  function automatic void clear_scan();
    phase     = SCAN_HUNT;
    tag_pos   = 0;
    depth     = 0;
    in_str    = 1'b0;
    esc_next  = 1'b0;
    first_obj = 1'b1;
    opened    = 1'b0;
    too_deep  = 1'b0;
  endfunction

  function automatic void extract_step(jsx_in_t it);
    logic [7:0] b;
    int         p;
    b = it.in_byte;
    if (!opened) begin
      due(CH_OPEN_BRACKET, 1'b0, 1'b0, 1'b0, 1'b0);
      opened = 1'b1;
    end
    if (it.byte_present) begin
      case (phase)
        SCAN_SEEK: begin
          if (b == CH_OPEN_BRACE) begin
            if (!first_obj) begin
              due(CH_COMMA, 1'b1, 1'b0, 1'b0, 1'b0);
              due(CH_OPEN_BRACE, 1'b0, 1'b0, 1'b0, 1'b0);
            end else begin
              due(CH_OPEN_BRACE, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            first_obj = 1'b0;
            phase     = SCAN_COPY;
            depth     = 1;
            in_str    = 1'b0;
            esc_next  = 1'b0;
          end
        end
        SCAN_COPY: begin
          due(b, 1'b0, 1'b0, 1'b0, 1'b0);
          if (esc_next) begin
            esc_next = 1'b0;
          end else if (in_str) begin
            if (b == CH_BACKSLASH) esc_next = 1'b1;
            else if (b == CH_QUOTE) in_str = 1'b0;
          end else if (b == CH_QUOTE) begin
            in_str = 1'b1;
          end else if (b == CH_OPEN_BRACE) begin
            if (depth >= int'(MAX_DEPTH)) too_deep = 1'b1;
            else depth++;
          end else if (b == CH_CLOSE_BRACE) begin
            if (depth > 0) depth--;
            if (depth == 0) begin
              phase    = SCAN_HUNT;
              tag_pos  = 0;
              in_str   = 1'b0;
              esc_next = 1'b0;
            end
          end
        end
        default: begin
          phase = SCAN_HUNT;
          p = tag_pos;
          if (p >= TAG_LEN) p = 0;
          if (b == SOURCE_TAG[79 - 8 * p -: 8]) begin
            p++;
            if (p == TAG_LEN) begin
              phase = SCAN_SEEK;
              p = 0;
            end
          end else if (p == 9 && b == CH_UNDERSCORE) begin
            p = 2;
          end else if (b == CH_QUOTE) begin
            p = 1;
          end else begin
            p = 0;
          end
          tag_pos = p;
        end
      endcase
    end
    if (it.in_last) begin
      due(CH_CLOSE_BRACKET, 1'b0, 1'b1, phase == SCAN_COPY, too_deep);
      clear_scan();
    end
  endfunction

  always @(posedge clk) begin : watch
    jsx_out_t want;
    if (rst) begin
      clear_scan();
      array_text_due.delete();
    end else begin
      if (push && !full) extract_step(in_item);
      if (pop && !empty) begin
        got++;
        if (out_item.object_start) starts++;
        if (array_text_due.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("%0t: unexpected item byte=%h start=%b last=%b inc=%b ovf=%b", $realtime,
                     out_item.out_byte, out_item.object_start, out_item.out_last,
                     out_item.incomplete, out_item.depth_overflow);
        end else begin
          want = array_text_due.pop_front();
          if (out_item.out_byte !== want.out_byte ||
              out_item.object_start !== want.object_start ||
              out_item.out_last !== want.out_last ||
              out_item.incomplete !== want.incomplete ||
              out_item.depth_overflow !== want.depth_overflow) begin
            bad++;
            if (bad <= 10)
              $display("%0t: item %0d exp byte=%h start=%b last=%b inc=%b ovf=%b, got %h %b %b %b %b",
                       $realtime, got, want.out_byte, want.object_start, want.out_last,
                       want.incomplete, want.depth_overflow, out_item.out_byte,
                       out_item.object_start, out_item.out_last, out_item.incomplete,
                       out_item.depth_overflow);
          end
        end
      end
    end
    mismatches   <= bad;
    pending      <= array_text_due.size();
    results_seen <= got;
    objects_seen <= starts;
  end

endmodule

@@ sim/tb.sv @@
// Testbench top for the source object extractor: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb;
  import jsx_pkg::*;

  logic     clk;
  logic     rst;
  logic     push;
  logic     full;
  jsx_in_t  in_item;
  logic     empty;
  logic     pop;
  jsx_out_t out_item;

  int       mismatches;
  int       pending;
  int       results_seen;
  int       objects_seen;

  int       items_sent;
  int       hold_req;
  bit       calm;
  logic [7:0] resp[$];
  string    tag_text = "\"_source\":";

  json_source_object_extractor_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  json_extract_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .pending     (pending),
    .results_seen(results_seen),
    .objects_seen(objects_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  initial begin : receiver
    int stall;
    int hold_left;
    stall = 0;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(0, 4);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic present, input logic last);
    logic taken;
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_item <= '{in_byte: b, byte_present: present, in_last: last};
    push <= 1'b1;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) resp.push_back(s[i]);
  endtask

  task automatic send_resp(input bit close);
    if (resp.size() == 0 && close) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    for (int i = 0; i < resp.size(); i++) begin
      if ($urandom_range(0, 11) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(resp[i], 1'b1, close && i == resp.size() - 1);
    end
  endtask

  task automatic wait_drain();
    int waited;
    push <= 1'b0;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending != 0 && waited < 20000);
    @(posedge clk);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return CH_QUOTE;
      1: return CH_UNDERSCORE;
      2: return CH_OPEN_BRACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic make_response();
    int open;
    int n;
    resp.delete();
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, 3)) resp.push_back(noise_byte());
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++) resp.push_back(tag_text[i]);
        continue;
      end
      push_text(tag_text);
      repeat ($urandom_range(0, 2)) resp.push_back(8'($urandom_range(0, 122)));
      resp.push_back(CH_OPEN_BRACE);
      open = 1;
      repeat ($urandom_range(1, 14)) begin
        case ($urandom_range(0, 5))
          0: if (open < 5) begin
            resp.push_back(CH_OPEN_BRACE);
            open++;
          end
          1: if (open > 1) begin
            resp.push_back(CH_CLOSE_BRACE);
            open--;
          end
          2: begin
            resp.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 4)) begin
              case ($urandom_range(0, 3))
                0: resp.push_back(CH_OPEN_BRACE);
                1: resp.push_back(CH_CLOSE_BRACE);
                2: begin
                  resp.push_back(CH_BACKSLASH);
                  resp.push_back(8'($urandom_range(0, 255)));
                end
                default: resp.push_back(8'($urandom_range(93, 122)));
              endcase
            end
            resp.push_back(CH_QUOTE);
          end
          3: resp.push_back(8'($urandom_range(48, 90)));
          default: resp.push_back(CH_COMMA);
        endcase
      end
      if ($urandom_range(0, 7) == 0) break;
      repeat (open) resp.push_back(CH_CLOSE_BRACE);
    end
  endtask

  initial begin : stimulus
    int target;
    items_sent = 0;
    hold_req = 0;
    calm = 1'b0;
    rst <= 1'b1;
    push <= 1'b0;
    in_item <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(8'h00, 1'b0, 1'b1);
    resp.delete();
    push_text("\"_\"_source\":x{\"\\\"}\"{}}");
    push_text("\"_source\"_source\":{");
    resp.push_back(8'h00);
    resp.push_back(8'hff);
    send_resp(1'b1);
    resp.delete();
    push_text("\"_source\":{}");
    send_resp(1'b0);
    send_item(CH_OPEN_BRACE, 1'b0, 1'b1);
    resp.delete();
    push_text(tag_text);
    repeat (257) resp.push_back(CH_OPEN_BRACE);
    resp.push_back(8'h61);
    send_resp(1'b1);

    hold_req = 60;
    resp.delete();
    repeat (3) push_text("\"_source\":{\"k\":[1,2]}");
    send_resp(1'b1);
    wait_drain();

    target = items_sent + 170;
    while (items_sent < target) begin
      if (items_sent > target - 40) calm = 1'b1;
      make_response();
      send_resp(1'b0);
      if ($urandom_range(0, 5) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      else send_item(resp.size() > 0 ? resp[resp.size() - 1] : 8'h20,
                     1'($urandom_range(0, 1)), 1'b1);
    end

    wait_drain();
    repeat (10) @(posedge clk);
    $display("tb: %0d items in, %0d results out, %0d objects extracted", items_sent,
             results_seen, objects_seen);
    $display("tb: ran empty, unbalanced, escaped, over-deep responses and back-pressure");
    if (pending != 0) $display("tb: %0d results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
